@@ rtl/ttge_pkg.sv @@
package ttge_pkg;

	localparam int COLS       = 80;
	localparam int ROWS       = 25;
	localparam int STYLE_BITS = 8;
	localparam int NCELLS     = ROWS * COLS;
	localparam int ADDR_W     = $clog2(NCELLS);
	localparam int CELL_W     = 104;
	localparam int TAB_STEP   = 8;

	localparam logic [7:0] LAST_COL = 8'(COLS - 1);
	localparam logic [7:0] LAST_ROW = 8'(ROWS - 1);
	localparam logic [7:0] STYLE_MASK = (STYLE_BITS >= 8) ? 8'hFF : 8'((1 << STYLE_BITS) - 1);

	localparam logic [1:0] CFG_FG    = 2'd0;
	localparam logic [1:0] CFG_BG    = 2'd1;
	localparam logic [1:0] CFG_STYLE = 2'd2;

	localparam logic [1:0] ERASE_TO_END   = 2'd0;
	localparam logic [1:0] ERASE_TO_START = 2'd1;
	localparam logic [1:0] ERASE_ALL      = 2'd2;
	localparam logic [1:0] ERASE_NONE     = 2'd3;

	typedef enum logic [4:0] {
		CMD_PRINT = 5'd0, CMD_NEWLINE = 5'd1, CMD_REVLINE = 5'd2, CMD_BKSP = 5'd3,
		CMD_CR = 5'd4, CMD_TAB = 5'd5, CMD_MOVE = 5'd6, CMD_UP = 5'd7, CMD_DOWN = 5'd8,
		CMD_FWD = 5'd9, CMD_BACK = 5'd10, CMD_ERASE_LINE = 5'd11,
		CMD_ERASE_DISP = 5'd12, CMD_STYLE_ON = 5'd13, CMD_STYLE_OFF = 5'd14,
		CMD_FG = 5'd15, CMD_BG = 5'd16, CMD_PEN_RESET = 5'd17, CMD_INIT = 5'd18,
		CMD_READ = 5'd19
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ_WAIT, ST_FILL, ST_SCROLL_RD, ST_SCROLL_WR
	} state_t;

	typedef struct packed {
		logic [4:0]  cmd;
		logic [31:0] code;
		logic [31:0] color;
		logic [2:0]  style_index;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [7:0]  count;
		logic [1:0]  mode;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  cursor_row;
		logic [7:0]  cursor_col;
		logic [31:0] read_code;
		logic [31:0] read_fg;
		logic [31:0] read_bg;
		logic [7:0]  read_style;
	} out_word_t;

	typedef struct packed {
		logic [31:0] code;
		logic [31:0] fg;
		logic [31:0] bg;
		logic [7:0]  style;
	} cell_t;

endpackage

@@ rtl/ttge_ram.sv @@
module ttge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/text_terminal_grid_engine.sv @@
// Character-cell terminal engine holding a ROWS x COLS grid in one cell RAM
// (code, colours and style per entry, one write and one registered read port).
// A command is taken when start is high and busy is low; its one result word
// appears with done high for a single cycle and cannot be stalled. Cursor, pen
// and read-free commands put done up in the cycle right after the accepting
// edge and busy stays high through it, so a new word waits until done drops.
// A read waits in ST_READ_WAIT for the RAM before done. A print answers like
// them unless it wraps at the bottom row. A scroll (newline at the bottom row,
// or a wrapping print there) moves every cell up one row, each through a read
// state and a write state, then blanks the last row at one cell per cycle.
// Erases other than mode ERASE_NONE blank one cell per cycle over their span,
// and init blanks the whole grid. After reset the cell RAM is swept with the
// reset pen while busy stays high; configuration writes are taken at any time.
module text_terminal_grid_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ttge_pkg::in_word_t  in_word,
	output logic                done,
	output ttge_pkg::out_word_t out_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import ttge_pkg::*;

	state_t state_q, state_d;

	logic [31:0] def_fg_q, def_bg_q;
	logic [7:0]  def_style_q;
	logic [31:0] pen_fg_q, pen_bg_q;
	logic [7:0]  pen_style_q;
	logic [7:0]  cur_y_q, cur_x_q;

	// Fill sweep runs over cell addresses fill_addr_q .. fill_end_q inclusive.
	logic [ADDR_W-1:0] fill_addr_q, fill_end_q;
	logic [ADDR_W-1:0] scr_addr_q;
	logic              done_q;
	out_word_t         out_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	cell_t             ram_wdata, ram_rdata;

	ttge_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE) || done_q;
	assign done      = done_q;
	assign out_word  = out_q;

	logic accept;
	assign accept = start && !busy;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] r, input logic [7:0] c);
		logic [ADDR_W+8:0] a;
		a = (ADDR_W + 9)'(r) * (ADDR_W + 9)'(COLS) + (ADDR_W + 9)'(c);
		return a[ADDR_W-1:0];
	endfunction

	function automatic logic [7:0] clamp8(input logic [8:0] v, input logic [7:0] hi);
		return (v > {1'b0, hi}) ? hi : v[7:0];
	endfunction

	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NCELLS - 1);
	localparam logic [ADDR_W-1:0] LROW_START = ADDR_W'(NCELLS - COLS);
	localparam logic [ADDR_W-1:0] ADDR_COLS  = ADDR_W'(COLS);

	// Command decode for the accepted word.
	logic       nx_fill, nx_read, nx_scroll;
	logic [ADDR_W-1:0] nx_fstart, nx_fend;
	logic [7:0] nx_y, nx_x;
	logic       at_bottom;
	logic [8:0] tab_x;
	logic [ADDR_W-1:0] cur_addr, row_start;

	assign at_bottom = ({1'b0, cur_y_q} + 9'd1) >= 9'(ROWS);
	assign cur_addr  = cell_addr(cur_y_q, cur_x_q);
	assign row_start = cell_addr(cur_y_q, 8'd0);
	assign tab_x     = {1'b0, cur_x_q & ~8'(TAB_STEP - 1)} + 9'(TAB_STEP);

	always_comb begin
		nx_fill   = 1'b0;
		nx_read   = 1'b0;
		nx_scroll = 1'b0;
		nx_fstart = '0;
		nx_fend   = LAST_ADDR;
		nx_y      = cur_y_q;
		nx_x      = cur_x_q;
		case (in_word.cmd)
			CMD_PRINT: begin
				if ({1'b0, cur_x_q} + 9'd1 >= 9'(COLS)) begin
					nx_x = 8'd0;
					if (at_bottom) nx_scroll = 1'b1;
					else nx_y = cur_y_q + 8'd1;
				end else begin
					nx_x = cur_x_q + 8'd1;
				end
			end
			CMD_NEWLINE: begin
				if (at_bottom) nx_scroll = 1'b1;
				else nx_y = cur_y_q + 8'd1;
			end
			CMD_REVLINE:  if (cur_y_q != 8'd0) nx_y = cur_y_q - 8'd1;
			CMD_BKSP:     if (cur_x_q != 8'd0) nx_x = cur_x_q - 8'd1;
			CMD_CR:       nx_x = 8'd0;
			CMD_TAB:      nx_x = clamp8(tab_x, LAST_COL);
			CMD_MOVE: begin
				nx_y = clamp8({1'b0, in_word.row}, LAST_ROW);
				nx_x = clamp8({1'b0, in_word.col}, LAST_COL);
			end
			CMD_UP:   nx_y = (in_word.count > cur_y_q) ? 8'd0 : cur_y_q - in_word.count;
			CMD_DOWN: nx_y = clamp8({1'b0, cur_y_q} + {1'b0, in_word.count}, LAST_ROW);
			CMD_FWD:  nx_x = clamp8({1'b0, cur_x_q} + {1'b0, in_word.count}, LAST_COL);
			CMD_BACK: nx_x = (in_word.count > cur_x_q) ? 8'd0 : cur_x_q - in_word.count;
			CMD_ERASE_LINE: begin
				nx_fill = (in_word.mode != ERASE_NONE);
				case (in_word.mode)
					ERASE_TO_END:   begin nx_fstart = cur_addr; nx_fend = row_start + ADDR_COLS - 1'b1; end
					ERASE_TO_START: begin nx_fstart = row_start; nx_fend = cur_addr; end
					default:        begin nx_fstart = row_start; nx_fend = row_start + ADDR_COLS - 1'b1; end
				endcase
			end
			CMD_ERASE_DISP: begin
				nx_fill = (in_word.mode != ERASE_NONE);
				case (in_word.mode)
					ERASE_TO_END:   begin nx_fstart = cur_addr; nx_fend = LAST_ADDR; end
					ERASE_TO_START: begin nx_fstart = '0; nx_fend = cur_addr; end
					default:        begin nx_fstart = '0; nx_fend = LAST_ADDR; end
				endcase
			end
			CMD_INIT: begin
				nx_fill = 1'b1;
				nx_y    = 8'd0;
				nx_x    = 8'd0;
			end
			CMD_READ: nx_read = 1'b1;
			default: ;
		endcase
	end

	logic fill_last, scr_last;
	assign fill_last = (fill_addr_q == fill_end_q);
	assign scr_last  = (scr_addr_q == LROW_START - 1'b1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:     if (fill_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (nx_read) state_d = ST_READ_WAIT;
					else if (nx_scroll) state_d = ST_SCROLL_RD;
					else if (nx_fill) state_d = ST_FILL;
				end
			end
			ST_READ_WAIT: state_d = ST_IDLE;
			ST_FILL:      if (fill_last) state_d = ST_IDLE;
			ST_SCROLL_RD: state_d = ST_SCROLL_WR;
			ST_SCROLL_WR: state_d = scr_last ? ST_FILL : ST_SCROLL_RD;
			default:      state_d = ST_IDLE;
		endcase
	end

	cell_t blank_cell;
	assign blank_cell = '{code: 32'd0, fg: pen_fg_q, bg: pen_bg_q, style: pen_style_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_addr_q;
		ram_wdata = blank_cell;
		ram_raddr = scr_addr_q + ADDR_COLS;
		case (state_q)
			ST_CLEAR, ST_FILL: ram_we = 1'b1;
			ST_IDLE: begin
				ram_raddr = cell_addr(clamp8({1'b0, in_word.row}, LAST_ROW),
					clamp8({1'b0, in_word.col}, LAST_COL));
				if (accept && in_word.cmd == CMD_PRINT) begin
					ram_we    = 1'b1;
					ram_waddr = cur_addr;
					ram_wdata = '{code: in_word.code, fg: pen_fg_q, bg: pen_bg_q,
						style: pen_style_q};
				end
			end
			ST_SCROLL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = scr_addr_q;
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			def_fg_q    <= 32'h00FF_FFFF;
			def_bg_q    <= '0;
			def_style_q <= '0;
			pen_fg_q    <= 32'h00FF_FFFF;
			pen_bg_q    <= '0;
			pen_style_q <= '0;
			cur_y_q     <= '0;
			cur_x_q     <= '0;
			fill_addr_q <= '0;
			fill_end_q  <= LAST_ADDR;
			scr_addr_q  <= '0;
			done_q      <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FG:    def_fg_q    <= cfg_data;
					CFG_BG:    def_bg_q    <= cfg_data;
					CFG_STYLE: def_style_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: fill_addr_q <= fill_addr_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						cur_y_q <= nx_y;
						cur_x_q <= nx_x;
						fill_addr_q <= nx_fstart;
						fill_end_q  <= nx_fend;
						scr_addr_q  <= '0;
						if (nx_scroll) begin
							fill_addr_q <= LROW_START;
							fill_end_q  <= LAST_ADDR;
						end
						case (in_word.cmd)
							CMD_STYLE_ON: if (32'(in_word.style_index) < STYLE_BITS)
								pen_style_q <= (pen_style_q | (8'd1 << in_word.style_index))
									& STYLE_MASK;
							CMD_STYLE_OFF: if (32'(in_word.style_index) < STYLE_BITS)
								pen_style_q <= (pen_style_q & ~(8'd1 << in_word.style_index))
									& STYLE_MASK;
							CMD_FG: pen_fg_q <= in_word.color;
							CMD_BG: pen_bg_q <= in_word.color;
							CMD_PEN_RESET, CMD_INIT: begin
								pen_fg_q    <= def_fg_q;
								pen_bg_q    <= def_bg_q;
								pen_style_q <= def_style_q & STYLE_MASK;
							end
							default: ;
						endcase
						if (!nx_read && !nx_fill && !nx_scroll) begin
							done_q <= 1'b1;
							out_q  <= '{cursor_row: nx_y, cursor_col: nx_x, read_code: '0,
								read_fg: '0, read_bg: '0, read_style: '0};
						end
					end
				end
				ST_READ_WAIT: begin
					done_q <= 1'b1;
					out_q  <= '{cursor_row: cur_y_q, cursor_col: cur_x_q,
						read_code: ram_rdata.code, read_fg: ram_rdata.fg,
						read_bg: ram_rdata.bg, read_style: ram_rdata.style};
				end
				ST_FILL: begin
					fill_addr_q <= fill_addr_q + 1'b1;
					if (fill_last) begin
						done_q <= 1'b1;
						out_q  <= '{cursor_row: cur_y_q, cursor_col: cur_x_q, read_code: '0,
							read_fg: '0, read_bg: '0, read_style: '0};
					end
				end
				ST_SCROLL_WR: scr_addr_q <= scr_addr_q + 1'b1;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("command taken while busy");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_y_q <= LAST_ROW) && (cur_x_q <= LAST_COL)) else $error("cursor off grid");
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ_WAIT) |=> done) else $error("read gave no result");
`endif

endmodule

@@ dv/text_terminal_grid_engine_tb.sv @@
`timescale 1ns / 100ps

module text_terminal_grid_engine_tb;
	import ttge_pkg::*;

	// Cycles without any accepted or returned word before the run is declared hung.
	// A full scroll walks the whole store, the longest sweep, so this leaves ample room.
	localparam int HANG_LIMIT = 60000;
	localparam int PHASES     = 6;
	localparam int PER_PHASE  = 265;

	// Scoreboard: keeps its own copy of the screen, cursor and pen, works out
	// the word each accepted command should produce and checks the returned words.
	class screen_scoreboard;
		cell_t       cells[NCELLS];
		int          cur_y, cur_x;
		logic [31:0] pen_fg, pen_bg, dflt_fg, dflt_bg;
		logic [7:0]  pen_style, dflt_style;
		out_word_t   pending[$];
		int          errors;

		function new();
			dflt_fg = 32'h00FF_FFFF;
			dflt_bg = '0;
			dflt_style = '0;
			errors = 0;
			cur_y = 0;
			cur_x = 0;
			load_pen();
			blank_rows(0, ROWS);
		endfunction

		function void load_pen();
			pen_fg = dflt_fg;
			pen_bg = dflt_bg;
			pen_style = dflt_style & STYLE_MASK;
		endfunction

		function void blank_cell(int r, int c);
			cells[r * COLS + c] = '{code: '0, fg: pen_fg, bg: pen_bg, style: pen_style};
		endfunction

		function void blank_span(int r, int from, int to);
			for (int c = from; c <= to && c < COLS; c++)
				blank_cell(r, c);
		endfunction

		function void blank_rows(int from, int to);
			for (int r = from; r < to && r < ROWS; r++)
				blank_span(r, 0, COLS - 1);
		endfunction

		function void line_feed();
			if (cur_y + 1 >= ROWS) begin
				for (int i = 0; i < NCELLS - COLS; i++)
					cells[i] = cells[i + COLS];
				blank_span(ROWS - 1, 0, COLS - 1);
			end else begin
				cur_y++;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				CFG_FG: begin
					dflt_fg = data;
				end
				CFG_BG: begin
					dflt_bg = data;
				end
				CFG_STYLE: begin
					dflt_style = data[7:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Called for each command word the block takes.
		function void note_command(in_word_t w);
			out_word_t exp_word;
			int        r, c, cnt;
			cell_t     hit;
			exp_word = '0;
			r = (w.row > LAST_ROW) ? LAST_ROW : w.row;
			c = (w.col > LAST_COL) ? LAST_COL : w.col;
			cnt = w.count;
			case (w.cmd)
				CMD_PRINT: begin
					cells[cur_y * COLS + cur_x] = '{code: w.code, fg: pen_fg, bg: pen_bg,
						style: pen_style};
					cur_x++;
					if (cur_x >= COLS) begin
						cur_x = 0;
						line_feed();
					end
				end
				CMD_NEWLINE: line_feed();
				CMD_REVLINE: if (cur_y > 0) cur_y--;
				CMD_BKSP: if (cur_x > 0) cur_x--;
				CMD_CR: cur_x = 0;
				CMD_TAB: begin
					cur_x = cur_x - cur_x % TAB_STEP + TAB_STEP;
					if (cur_x > COLS - 1) cur_x = COLS - 1;
				end
				CMD_MOVE: begin
					cur_y = r;
					cur_x = c;
				end
				CMD_UP: cur_y = (cnt > cur_y) ? 0 : cur_y - cnt;
				CMD_DOWN: cur_y = (cur_y + cnt > ROWS - 1) ? ROWS - 1 : cur_y + cnt;
				CMD_FWD: cur_x = (cur_x + cnt > COLS - 1) ? COLS - 1 : cur_x + cnt;
				CMD_BACK: cur_x = (cnt > cur_x) ? 0 : cur_x - cnt;
				CMD_ERASE_LINE: begin
					if (w.mode == ERASE_TO_END) blank_span(cur_y, cur_x, COLS - 1);
					else if (w.mode == ERASE_TO_START) blank_span(cur_y, 0, cur_x);
					else if (w.mode == ERASE_ALL) blank_span(cur_y, 0, COLS - 1);
				end
				CMD_ERASE_DISP: begin
					if (w.mode == ERASE_TO_END) begin
						blank_span(cur_y, cur_x, COLS - 1);
						blank_rows(cur_y + 1, ROWS);
					end else if (w.mode == ERASE_TO_START) begin
						blank_span(cur_y, 0, cur_x);
						blank_rows(0, cur_y);
					end else if (w.mode == ERASE_ALL) begin
						blank_rows(0, ROWS);
					end
				end
				CMD_STYLE_ON: if (w.style_index < STYLE_BITS)
					pen_style = (pen_style | (8'd1 << w.style_index)) & STYLE_MASK;
				CMD_STYLE_OFF: if (w.style_index < STYLE_BITS)
					pen_style = (pen_style & ~(8'd1 << w.style_index)) & STYLE_MASK;
				CMD_FG: pen_fg = w.color;
				CMD_BG: pen_bg = w.color;
				CMD_PEN_RESET: load_pen();
				CMD_INIT: begin
					cur_x = 0;
					cur_y = 0;
					load_pen();
					blank_rows(0, ROWS);
				end
				CMD_READ: begin
					hit = cells[r * COLS + c];
					exp_word.read_code = hit.code;
					exp_word.read_fg = hit.fg;
					exp_word.read_bg = hit.bg;
					exp_word.read_style = hit.style;
				end
				default: begin
				end
			endcase
			exp_word.cursor_row = 8'(cur_y);
			exp_word.cursor_col = 8'(cur_x);
			pending.push_back(exp_word);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("cursor_row", want.cursor_row, got.cursor_row);
			compare_field("cursor_col", want.cursor_col, got.cursor_col);
			compare_field("read_code", want.read_code, got.read_code);
			compare_field("read_fg", want.read_fg, got.read_fg);
			compare_field("read_bg", want.read_bg, got.read_bg);
			compare_field("read_style", want.read_style, got.read_style);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    in_word;
	logic        done;
	out_word_t   out_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	screen_scoreboard screen;
	int               quiet_cycles;
	int               idle_pct;

	text_terminal_grid_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_word   (in_word),
		.done      (done),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result words are only ever one cycle wide, so every edge with done high
	// carries a word that has to be checked right there.
	always @(posedge clk) begin
		if (arst_n && done)
			screen.check_result(out_word);
	end

	// Hang detection: any accepted word on any channel restarts the count.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("[text_terminal_grid_engine] ERROR");
				$finish;
			end
		end
	end

	// Presents one command word and holds it until the block takes it. Start is
	// left high unless an idle gap is drawn, so back-to-back words need no extra assignment.
	task automatic send_command(in_word_t w);
		in_word <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		screen.note_command(w);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (screen.pending.size() != 0);
	endtask

	// Leaves valid high so that writes can follow back to back; the caller
	// drops it after the last one.
	task automatic write_register(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		screen.write_reg(idx, data);
	endtask

	function automatic in_word_t make_command(cmd_t op);
		in_word_t w;
		w = '{cmd: op, code: $urandom, color: $urandom,
			style_index: 3'($urandom_range(0, 7)),
			row: 8'($urandom_range(0, 255)), col: 8'($urandom_range(0, 255)),
			count: 8'($urandom_range(0, 255)), mode: 2'($urandom_range(0, 3))};
		return w;
	endfunction

	// Random command with scrolls and whole-screen sweeps kept rare, since each
	// of those keeps the block busy for a walk over the cell store.
	function automatic in_word_t random_command();
		in_word_t w;
		bit       at_bottom;
		w = make_command(CMD_PRINT);
		if ($urandom_range(0, 99) >= 35)
			w.cmd = 5'($urandom_range(0, 31));
		at_bottom = (screen.cur_y == ROWS - 1);
		if ((w.cmd == CMD_ERASE_DISP || w.cmd == CMD_INIT) && $urandom_range(0, 7) != 0)
			w.cmd = CMD_MOVE;
		if (at_bottom && (w.cmd == CMD_NEWLINE ||
			(w.cmd == CMD_PRINT && screen.cur_x == COLS - 1)) && $urandom_range(0, 19) != 0)
			w.cmd = CMD_UP;
		// Reads and moves land near the cursor half the time so recent writes get seen.
		if ($urandom_range(0, 1) == 0) begin
			w.row = 8'(screen.cur_y + $urandom_range(0, 1));
			w.col = 8'(screen.cur_x - $urandom_range(0, 2));
		end
		if ($urandom_range(0, 1) == 0)
			w.count = 8'($urandom_range(0, 9));
		return w;
	endfunction

	initial begin
		in_word_t w;
		logic [31:0] fg_set[PHASES], bg_set[PHASES], st_set[PHASES];

		screen = new();
		quiet_cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// Wait out the clearing sweep before sending the first command.
		do @(posedge clk); while (busy);

		// Directed part: extreme field values and the top-left and bottom-right corners.
		send_command(make_command(CMD_INIT));
		w = make_command(CMD_PRINT); w.code = '0; send_command(w);
		w = make_command(CMD_PRINT); w.code = '1; send_command(w);
		w = make_command(CMD_STYLE_ON); w.style_index = 3'd7; send_command(w);
		w = make_command(CMD_STYLE_ON); w.style_index = 3'd0; send_command(w);
		w = make_command(CMD_FG); w.color = '1; send_command(w);
		w = make_command(CMD_BG); w.color = '0; send_command(w);
		w = make_command(CMD_STYLE_OFF); w.style_index = 3'd7; send_command(w);
		w = make_command(CMD_MOVE); w.row = 8'hFF; w.col = 8'hFF; send_command(w);
		send_command(make_command(CMD_TAB));
		w = make_command(CMD_PRINT); w.code = 32'hA5A5_5A5A; send_command(w);
		send_command(make_command(CMD_NEWLINE));
		w = make_command(CMD_READ); w.row = 8'hFF; w.col = 8'hFF; send_command(w);
		w = make_command(CMD_READ); w.row = 8'(ROWS - 2); w.col = 8'hFF; send_command(w);
		w = make_command(CMD_UP); w.count = 8'hFF; send_command(w);
		w = make_command(CMD_FWD); w.count = 8'hFF; send_command(w);
		send_command(make_command(CMD_BKSP));
		w = make_command(CMD_DOWN); w.count = 8'd3; send_command(w);
		send_command(make_command(CMD_REVLINE));
		w = make_command(CMD_BACK); w.count = 8'hFF; send_command(w);
		send_command(make_command(CMD_CR));
		for (int m = 0; m < 4; m++) begin
			w = make_command(CMD_ERASE_LINE); w.mode = 2'(m); send_command(w);
		end
		w = make_command(CMD_ERASE_DISP); w.mode = ERASE_NONE; send_command(w);
		w = make_command(CMD_ERASE_DISP); w.mode = ERASE_TO_START; send_command(w);
		send_command(make_command(CMD_PEN_RESET));
		w = make_command(CMD_READ); w.cmd = 5'd31; send_command(w);
		w = make_command(CMD_READ); w.row = '0; w.col = '0; send_command(w);

		// Register settings per phase: defaults, all zeros, all ones, then random.
		fg_set = '{32'h00FF_FFFF, 32'h0, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};
		bg_set = '{32'h0, 32'h0, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};
		st_set = '{32'h0, 32'h0, 32'hFF, $urandom, $urandom, $urandom};

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			do @(posedge clk); while (busy);
			write_register(CFG_FG, fg_set[ph]);
			write_register(CFG_BG, bg_set[ph]);
			write_register(CFG_STYLE, st_set[ph]);
			cfg_valid <= 1'b0;
			// Sender idle rate cycles through none, heavy and light.
			idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 76 : 23;
			send_command(make_command(CMD_PEN_RESET));
			for (int i = 0; i < PER_PHASE; i++) begin
				if (ph == 3 && i == PER_PHASE / 2)
					drain_results();
				send_command(random_command());
			end
		end

		drain_results();
		repeat (100) @(posedge clk);
		if (screen.errors == 0 && screen.pending.size() == 0) begin
			$display("[text_terminal_grid_engine] OK");
		end else begin
			$display("[text_terminal_grid_engine] ERROR");
		end
		$finish;
	end

endmodule
